### design/stet_pkg.sv
// Package: shared types, codes and constants of the timer event table.
package stet_pkg;

    localparam int SLOTS_DEF = 8;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;
    localparam logic [1:0] CMD_SVC = 2'd2;
    localparam logic [1:0] CMD_WAKE = 2'd3;

    localparam logic [2:0] KIND_ADDED = 3'd0;
    localparam logic [2:0] KIND_FULL = 3'd1;
    localparam logic [2:0] KIND_FIRED = 3'd2;
    localparam logic [2:0] KIND_DONE = 3'd3;
    localparam logic [2:0] KIND_WAKE = 3'd4;

    localparam logic CFG_MIN_LEAD = 1'b0;
    localparam logic CFG_TICKS_MS = 1'b1;

    localparam logic [15:0] MIN_LEAD_RST = 16'd100;
    localparam logic [19:0] TICKS_MS_RST = 20'd24000;

    localparam int IN_W = 96;
    localparam int OUT_W = 104;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [63:0] event_stamp;
        logic [31:0] wake_compare;
        logic        last;
    } t_result;

endpackage

### design/stet_alu.sv
// Shared 64-bit add and compare unit.
module stet_alu import stet_pkg::*; (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_sum,
    output logic        o_ge
);
    assign o_sum = i_a + i_b;
    assign o_ge  = (i_a >= i_b);
endmodule

### design/software_timer_event_table_core.sv
// Top level: timer event table with 64-bit time base and sequencer.
//  channel | dir | signals
//  s_axis  | in  | tvalid tready tdata
//  m_axis  | out | tvalid tready tdata tlast
//  cfg     | in  | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data
// The shared 64-bit adder/comparator visits one slot per cycle while no fired
// slot waits for the output; the wake limit product is registered in its own
// state before it is added to the time base. A fired slot waits while the output
// register is full; the input stays stalled while a result waits there. Reset is
// synchronous and clears used marks, time base and control registers.
module software_timer_event_table_core import stet_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // command[1:0], counter_low[33:2], delay_ticks[65:34], repeat_req[66],
    // handle[74:67], idle_limit_ms[90:75], zero pad
    input  logic [IN_W-1:0]    s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // kind[2:0], slot[5:3], event_stamp[69:6], wake_compare[101:70], pad
    output logic [OUT_W-1:0]   m_axis_tdata,
    output logic               m_axis_tlast,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [19:0]        i_cfg_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TIME = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_HOR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [SLOTS-1:0] r_used, r_per;
    logic [63:0] r_dl [SLOTS];
    logic [31:0] r_iv [SLOTS];
    logic [31:0] r_high, r_lastlow;
    logic [15:0] r_min_lead;
    logic [19:0] r_tpm;
    logic [1:0]  r_cmd;
    logic [31:0] r_low, r_delay;
    logic        r_rep;
    logic [7:0]  r_handle;
    logic [15:0] r_idle;
    logic [63:0] r_now, r_floor, r_best, r_lim;
    logic        r_found;
    logic [CW-1:0] r_idx;
    logic        r_ovalid;
    t_result     r_res;

    logic [SW-1:0] idx;
    logic [63:0] a, b, sum;
    logic        ge;
    logic [63:0] cand;

    assign idx = r_idx[SW-1:0];
    assign cand = r_dl[idx];

    stet_alu u_alu (.i_a(a), .i_b(b), .o_sum(sum), .o_ge(ge));

    always_comb begin
        a = r_now;
        b = 64'd0;
        unique case (r_state)
            S_TIME: b = {32'd0, r_delay};
            S_SCAN: begin
                if (r_cmd == CMD_SVC) begin
                    if (r_per[idx]) begin
                        b = {32'd0, r_iv[idx]};
                    end else begin
                        b = cand;
                    end
                end else begin
                    a = cand;
                    b = r_floor;
                end
            end
            S_HOR: b = r_lim;
            S_FIN: begin
                a = r_best;
                b = r_lim;
            end
            default: ;
        endcase
    end

    logic [SLOTS-1:0] free_vec;
    logic             any_free;
    logic [SW-1:0]    first_free;
    always_comb begin
        free_vec = ~r_used;
        any_free = |free_vec;
        first_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) first_free = SW'(i);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast = r_res.last;
    assign m_axis_tdata = {2'b0, r_res.wake_compare, r_res.event_stamp, r_res.slot,
        r_res.kind};

    logic in_xfer, out_free, hit, per_ge, res_load;
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_TIME;
            S_TIME: begin
                unique case (r_cmd)
                    CMD_ADD: n_state = S_OUT;
                    CMD_DEL: n_state = S_IDLE;
                    default: n_state = S_SCAN;
                endcase
            end
            S_SCAN: begin
                if (r_idx == CW'(SLOTS)) begin
                    n_state = (r_cmd == CMD_SVC) ? S_OUT : S_MUL;
                end
            end
            S_MUL:  n_state = S_HOR;
            S_HOR:  n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // service: due when now >= deadline
    assign per_ge = (r_now >= cand);
    assign hit = (r_idx < CW'(SLOTS)) && r_used[idx] && per_ge;
    assign res_load = out_free && ((r_state == S_OUT) ||
        ((r_state == S_SCAN) && (r_cmd == CMD_SVC) && hit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_per <= '0;
            r_high <= '0;
            r_lastlow <= '0;
            r_min_lead <= MIN_LEAD_RST;
            r_tpm <= TICKS_MS_RST;
            r_ovalid <= 1'b0;
            r_idx <= '0;
            r_res <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN_LEAD) r_min_lead <= i_cfg_data[15:0];
                else r_tpm <= i_cfg_data;
            end
            r_ovalid <= res_load || (r_ovalid && !m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd <= s_axis_tdata[1:0];
                        r_low <= s_axis_tdata[33:2];
                        r_delay <= s_axis_tdata[65:34];
                        r_rep <= s_axis_tdata[66];
                        r_handle <= s_axis_tdata[74:67];
                        r_idle <= s_axis_tdata[90:75];
                        if (s_axis_tdata[33:2] < r_lastlow) begin
                            r_now <= {r_high + 32'd1, s_axis_tdata[33:2]};
                            r_high <= r_high + 32'd1;
                        end else begin
                            r_now <= {r_high, s_axis_tdata[33:2]};
                        end
                        r_lastlow <= s_axis_tdata[33:2];
                    end
                end
                S_TIME: begin
                    r_idx <= '0;
                    r_found <= 1'b0;
                    r_best <= '1;
                    r_floor <= r_now + {48'd0, r_min_lead};
                    if (r_cmd == CMD_ADD) begin
                        if (any_free) begin
                            r_used[first_free] <= 1'b1;
                            r_per[first_free] <= r_rep;
                            r_dl[first_free] <= sum;
                            r_iv[first_free] <= r_rep ? r_delay : 32'd0;
                            r_res <= t_result'{KIND_ADDED, 3'(first_free), 64'd0, 32'd0,
                                1'b1};
                        end else begin
                            r_res <= t_result'{KIND_FULL, 3'd0, 64'd0, 32'd0, 1'b1};
                        end
                    end else if (r_cmd == CMD_DEL) begin
                        if (r_handle < 8'(SLOTS)) r_used[SW'(r_handle)] <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_cmd == CMD_SVC) begin
                        if (r_idx != CW'(SLOTS)) begin
                            if (!hit) begin
                                r_idx <= r_idx + CW'(1);
                            end else if (out_free) begin
                                r_res <= t_result'{KIND_FIRED, 3'(idx), cand, 32'd0, 1'b0};
                                if (r_per[idx]) r_dl[idx] <= sum;
                                else r_used[idx] <= 1'b0;
                                r_idx <= r_idx + CW'(1);
                            end
                        end
                    end else if (r_idx != CW'(SLOTS)) begin
                        if (r_used[idx] && ge && cand < r_best) begin
                            r_best <= cand;
                            r_found <= 1'b1;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_MUL: r_lim <= 64'(r_tpm) * 64'(r_idle);
                S_HOR: r_lim <= sum;
                S_FIN: begin
                    r_res <= t_result'{KIND_WAKE, 3'd0, 64'd0,
                        ((r_found && !ge) ? r_best[31:0] : r_lim[31:0]), 1'b1};
                end
                S_OUT: begin
                    if (out_free && r_cmd == CMD_SVC) begin
                        r_res <= t_result'{KIND_DONE, 3'd0, 64'd0, 32'd0, 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE)
        else $error("ready outside idle");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CW'(SLOTS))
        else $error("slot index overrun");
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmd == CMD_SVC && hit && out_free) |=> r_ovalid)
        else $error("fired slot not reported");
`endif
endmodule

### tb/sv/software_timer_event_table_core_tb.sv
// Testbench for the timer event table core: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module software_timer_event_table_core_tb;
    import stet_pkg::*;

    localparam int NSLOT = SLOTS_DEF;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] counter_low;
        logic [31:0] delay_ticks;
        logic        repeat_req;
        logic [7:0]  handle;
        logic [15:0] idle_limit_ms;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [19:0] i_cfg_data = '0;

    software_timer_event_table_core i_dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic        tm_used [NSLOT];
    logic        tm_periodic [NSLOT];
    logic [63:0] tm_deadline [NSLOT];
    logic [31:0] tm_interval [NSLOT];
    logic [31:0] tm_high;
    logic [31:0] tm_last_low;
    logic [15:0] tm_min_lead;
    logic [19:0] tm_ticks_ms;

    t_result pending_results[$];
    int errors = 0;
    int hold_off = 0;
    bit stall_enable = 1'b1;
    logic [31:0] clk_low = 0;

    function automatic t_result mk(logic [2:0] kind, logic [2:0] slot, logic [63:0] stamp,
                                   logic [31:0] cmp, logic last);
        t_result r;
        r.kind = kind;
        r.slot = slot;
        r.event_stamp = stamp;
        r.wake_compare = cmp;
        r.last = last;
        return r;
    endfunction

    task automatic predict_timer(t_cmd c);
        logic [63:0] now, floor_t, horizon, earliest, limit;
        bit found;
        int fs;
        if (c.counter_low < tm_last_low) tm_high = tm_high + 1;
        tm_last_low = c.counter_low;
        now = {tm_high, c.counter_low};
        case (c.command)
            CMD_ADD: begin
                fs = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (fs < 0 && !tm_used[i]) fs = i;
                if (fs < 0) begin
                    pending_results.push_back(mk(KIND_FULL, 0, 0, 0, 1));
                end else begin
                    tm_used[fs] = 1;
                    tm_periodic[fs] = c.repeat_req;
                    tm_deadline[fs] = now + c.delay_ticks;
                    tm_interval[fs] = c.repeat_req ? c.delay_ticks : 0;
                    pending_results.push_back(mk(KIND_ADDED, fs[2:0], 0, 0, 1));
                end
            end
            CMD_DEL: begin
                if (c.handle < NSLOT) tm_used[c.handle] = 0;
            end
            CMD_SVC: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tm_used[i] && now >= tm_deadline[i]) begin
                        pending_results.push_back(mk(KIND_FIRED, i[2:0], tm_deadline[i], 0, 0));
                        if (tm_periodic[i]) tm_deadline[i] = now + tm_interval[i];
                        else tm_used[i] = 0;
                    end
                end
                pending_results.push_back(mk(KIND_DONE, 0, 0, 0, 1));
            end
            default: begin
                floor_t = now + tm_min_lead;
                limit = 64'(tm_ticks_ms) * 64'(c.idle_limit_ms);
                horizon = now + limit;
                earliest = '1;
                found = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (tm_used[i] && tm_deadline[i] >= floor_t && tm_deadline[i] < earliest) begin
                        earliest = tm_deadline[i];
                        found = 1;
                    end
                pending_results.push_back(mk(KIND_WAKE, 0, 0,
                    (found && earliest < horizon) ? earliest[31:0] : horizon[31:0], 1));
            end
        endcase
    endtask

    // sender
    int burst_left = 0;

    task automatic send_cmd(t_cmd c);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata = {5'd0, c.idle_limit_ms, c.handle, c.repeat_req, c.delay_ticks,
                        c.counter_low, c.command};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_timer(c);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_op(logic [1:0] cmd, logic [31:0] dt, logic rep = 0,
                           logic [7:0] h = 0, logic [15:0] idle = 0, int step = 50);
        t_cmd c;
        clk_low = clk_low + step;
        c.command = cmd;
        c.counter_low = clk_low;
        c.delay_ticks = dt;
        c.repeat_req = rep;
        c.handle = h;
        c.idle_limit_ms = idle;
        send_cmd(c);
    endtask

    task automatic write_reg(logic idx, logic [19:0] val);
        int n;
        n = 0;
        while (pending_results.size() != 0 && n < 100000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (30) @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MIN_LEAD) tm_min_lead = val[15:0];
        else tm_ticks_ms = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern and long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_enable) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) > 2);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = mk(m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[69:6],
                     m_axis_tdata[101:70], m_axis_tlast);
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d", got.kind);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (got.kind !== exp.kind) begin
                    $error("kind: expected %0d actual %0d", exp.kind, got.kind); errors++;
                end
                if (got.slot !== exp.slot) begin
                    $error("slot: expected %0d actual %0d", exp.slot, got.slot); errors++;
                end
                if (got.event_stamp !== exp.event_stamp) begin
                    $error("event_stamp: expected %h actual %h", exp.event_stamp,
                           got.event_stamp);
                    errors++;
                end
                if (got.wake_compare !== exp.wake_compare) begin
                    $error("wake_compare: expected %h actual %h", exp.wake_compare,
                           got.wake_compare);
                    errors++;
                end
                if (got.last !== exp.last) begin
                    $error("last: expected %0d actual %0d", exp.last, got.last); errors++;
                end
            end
        end
    end

    task automatic test_add_full_delete();
        for (int i = 0; i < NSLOT; i++) send_op(CMD_ADD, 32'd1000 + i, i[0]);
        send_op(CMD_ADD, 32'hFFFF_FFFF, 1);
        send_op(CMD_DEL, 0, 0, 8'd255);
        send_op(CMD_DEL, 0, 0, 8'd8);
        send_op(CMD_DEL, 0, 0, 8'd3);
        send_op(CMD_DEL, 0, 0, 8'd3);
        send_op(CMD_ADD, 32'd0, 0);
    endtask

    task automatic test_service_wrap();
        send_op(CMD_SVC, 0, 0, 0, 0, 5000);
        send_op(CMD_SVC, 0, 0, 0, 0, 0);
        clk_low = 32'hFFFF_FF00;
        send_op(CMD_ADD, 32'd300, 1, 0, 0, 0);
        send_op(CMD_DEL, 0, 0, 8'd1, 0, 32'h200);
        send_op(CMD_SVC, 0, 0, 0, 0, 32'h1000);
    endtask

    task automatic test_wake();
        send_op(CMD_WAKE, 0, 0, 0, 16'hFFFF);
        send_op(CMD_WAKE, 0, 0, 0, 16'd0);
        send_op(CMD_ADD, 32'd50, 0);
        send_op(CMD_WAKE, 0, 0, 0, 16'd1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MIN_LEAD, 20'd0);
        write_reg(CFG_TICKS_MS, 20'd1);
        send_op(CMD_WAKE, 0, 0, 0, 16'd7);
        write_reg(CFG_MIN_LEAD, 20'hFFFF);
        write_reg(CFG_TICKS_MS, 20'd1000000);
        send_op(CMD_WAKE, 0, 0, 0, 16'hFFFF);
        write_reg(CFG_TICKS_MS, 20'd0);
        send_op(CMD_WAKE, 0, 0, 0, 16'd9);
    endtask

    task automatic test_random(int n);
        t_cmd c;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) hold_off = 200;
            if (k % 70 == 69) begin
                write_reg(CFG_MIN_LEAD, 20'($urandom_range(0, 65535)));
                write_reg(CFG_TICKS_MS, 20'($urandom_range(1, 1000000)));
            end
            stall_enable = (k % 60) > 15;
            c.counter_low = ($urandom_range(0, 19) == 0) ? $urandom
                            : clk_low + $urandom_range(0, 30000);
            clk_low = c.counter_low;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c.command = CMD_ADD;
                4: c.command = CMD_DEL;
                5, 6, 7: c.command = CMD_SVC;
                default: c.command = CMD_WAKE;
            endcase
            c.delay_ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60000);
            c.repeat_req = $urandom_range(0, 1);
            c.handle = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            c.idle_limit_ms = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                              : 16'($urandom_range(0, 3));
            send_cmd(c);
        end
    endtask

    initial begin
        int n;
        for (int i = 0; i < NSLOT; i++) begin
            tm_used[i] = 0; tm_periodic[i] = 0; tm_deadline[i] = 0; tm_interval[i] = 0;
        end
        tm_high = 0;
        tm_last_low = 0;
        tm_min_lead = MIN_LEAD_RST;
        tm_ticks_ms = TICKS_MS_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_add_full_delete();
        test_service_wrap();
        test_wake();
        test_config_extremes();
        test_random(190);
        n = 0;
        while (pending_results.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (40) @(negedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
